@@ design/btb_pkg.sv @@
`timescale 1ns / 1ps

package btb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned TagW     = 30;
  localparam int unsigned CtrW     = 2;

  localparam logic [CfgIdxW-1:0] CFG_BTB_ENTRIES     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HISTORY_BITS    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TAG_BITS        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_COUNTER = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_HISTORY  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_TABLE    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SHARE_MODE      = 3'd6;

  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  localparam logic [1:0] SHARE_NONE = 2'd0;
  localparam logic [1:0] SHARE_LOW  = 2'd1;
  localparam logic [1:0] SHARE_HIGH = 2'd2;

  localparam logic [CtrW-1:0] CTR_MAX  = 2'd3;
  localparam logic [CtrW-1:0] CTR_MIN  = 2'd0;
  localparam logic [CtrW-1:0] CTR_WEAK_TAKEN = 2'd2;

  function automatic logic [CtrW-1:0] ctr_train(input logic [CtrW-1:0] c, input logic tk);
    logic [CtrW-1:0] r;
    r = c;
    if (tk) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

@@ design/btb_index.sv @@
`timescale 1ns / 1ps

// Decodes the configured geometry and splits a pc into entry index and tag.
module btb_index #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned MAX_HISTORY = 8,
  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic [31:0]            pc_i,
  input  logic [5:0]             btb_entries_i,
  input  logic [3:0]             history_bits_i,
  input  logic [4:0]             tag_bits_i,
  input  logic [1:0]             share_mode_i,
  output logic [IW-1:0]          idx_o,
  output logic [btb_pkg::TagW-1:0] tag_o,
  output logic [MAX_HISTORY-1:0] hmask_o,
  output logic [MAX_HISTORY-1:0] share_x_o
);

  logic [10:0] n;
  logic [4:0]  k;
  logic [4:0]  tb;
  logic [3:0]  hl;
  logic [btb_pkg::TagW-1:0] tmask;
  logic [IW-1:0] imask;

  always_comb begin
    n = {5'd0, btb_entries_i};
    if (n == 11'd0) n = 11'd1;
    if (n > 11'(MAX_ENTRIES)) n = 11'(MAX_ENTRIES);
    k = 5'd0;
    for (int i = 0; i < 11; i++) begin
      if (n[i]) k = 5'(i);
    end
    tb = tag_bits_i;
    if (tb > 5'd30 - k) tb = 5'd30 - k;
    tmask = (btb_pkg::TagW'(1) << tb) - btb_pkg::TagW'(1);
    tag_o = (pc_i[31:2] >> k) & tmask;
    imask = IW'((32'd1 << k) - 32'd1);
    idx_o = pc_i[2 +: IW] & imask;

    hl = history_bits_i;
    if (hl == 4'd0) hl = 4'd1;
    if (hl > 4'(MAX_HISTORY)) hl = 4'(MAX_HISTORY);
    hmask_o = MAX_HISTORY'((16'd1 << hl) - 16'd1);

    case (share_mode_i)
      btb_pkg::SHARE_LOW:  share_x_o = pc_i[2 +: MAX_HISTORY] & hmask_o;
      btb_pkg::SHARE_HIGH: share_x_o = pc_i[16 +: MAX_HISTORY] & hmask_o;
      default:             share_x_o = '0;
    endcase
  end

endmodule

@@ design/btb_two_level_branch_predictor.sv @@
`timescale 1ns / 1ps

// Branch target buffer with a two-level direction predictor.
// Input channel (in_valid_i/in_ready_o) carries one item per transfer:
// mode 0 predicts for pc, mode 1 resolves a branch and trains the tables.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per item.
// For a predict or a hitting update, from transfer to result
// the entry memory is read at the transfer, then the counter memory, then the
// result is registered. An update that misses with per-entry counter tables
// first clears the entry's counter row, one counter per cycle, before the
// counter memory stage. One item is in flight at a time; the next input
// transfer can be taken as soon as the result is registered.
// The output register holds a result while the receiver stalls; the block
// keeps it and waits with the next result until it is taken.
// Reset clears valid bits, history, statistics and shared-table valid bits;
// no clearing pass is needed. A configuration write does the same with the
// new register value and must only occur while the block is idle.
module btb_two_level_branch_predictor #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned MAX_HISTORY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [btb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [btb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] target_i,
  input  logic        taken_i,
  input  logic [31:0] predicted_target_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        predict_taken_o,
  output logic [31:0] next_pc_o,
  output logic        flush_o,
  output logic [31:0] branch_count_o,
  output logic [31:0] flush_count_o
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned HW = MAX_HISTORY;
  localparam int unsigned RowLen = 1 << HW;
  localparam int unsigned CtrDepth = MAX_ENTRIES * RowLen;

  typedef struct packed {
    logic [btb_pkg::TagW-1:0] tag;
    logic [31:0]              target;
    logic [HW-1:0]            hist;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CLR,
    S_CRD
  } state_e;

  // Configuration registers.
  logic [5:0] btb_entries_q;
  logic [3:0] history_bits_q;
  logic [4:0] tag_bits_q;
  logic [1:0] initial_counter_q;
  logic       global_history_sel_q;
  logic       global_table_sel_q;
  logic [1:0] share_mode_q;
  logic       cfg_hit;

  // Control state.
  state_e state_q;
  logic [MAX_ENTRIES-1:0] entry_valid_q;
  logic [RowLen-1:0]      shared_valid_q;
  logic [HW-1:0]          shared_history_q;
  logic [31:0]            branches_q;
  logic [31:0]            flushes_q;
  logic                   out_valid_q;
  logic [HW-1:0]          clr_cnt_q;
  logic                   use_init_q;

  // Item registers.
  logic          mode_q;
  logic [31:0]   pc_q;
  logic [31:0]   target_q;
  logic          taken_q;
  logic [31:0]   pred_q;
  logic [IW-1:0] idx_q;
  logic [btb_pkg::TagW-1:0] tag_q;
  logic [HW-1:0] hmask_q;
  logic [HW-1:0] share_x_q;
  logic          hit_q;
  logic [HW-1:0] cidx_q;
  logic          flush_q;

  // Output registers.
  logic        predict_taken_q;
  logic [31:0] next_pc_q;
  logic        flush_out_q;
  logic [31:0] branch_count_q;
  logic [31:0] flush_count_q;

  // Memories.
  entry_t                  entry_mem [MAX_ENTRIES];
  entry_t                  entry_rd_q;
  logic [btb_pkg::CtrW-1:0] ectr_mem [CtrDepth];
  logic [btb_pkg::CtrW-1:0] ectr_rd_q;
  logic [btb_pkg::CtrW-1:0] sctr_mem [RowLen];
  logic [btb_pkg::CtrW-1:0] sctr_rd_q;
  logic                     svalid_rd_q;

  logic [IW-1:0]          in_idx;
  logic [btb_pkg::TagW-1:0] in_tag;
  logic [HW-1:0]          in_hmask;
  logic [HW-1:0]          in_share_x;

  btb_index #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_HISTORY (MAX_HISTORY)
  ) u_index (
    .pc_i           (pc_i),
    .btb_entries_i  (btb_entries_q),
    .history_bits_i (history_bits_q),
    .tag_bits_i     (tag_bits_q),
    .share_mode_i   (share_mode_q),
    .idx_o          (in_idx),
    .tag_o          (in_tag),
    .hmask_o        (in_hmask),
    .share_x_o      (in_share_x)
  );

  logic in_xfer;
  logic out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Lookup stage: entry data is available from the entry memory.
  logic          look_hit;
  logic [HW-1:0] look_hist;
  logic [HW-1:0] look_cidx;
  logic [HW-1:0] look_new_hist;
  logic          look_flush;
  logic          look_clear;
  logic [31:0]   seq_pc;

  assign seq_pc = pc_q + 32'd4;

  always_comb begin
    look_hit = entry_valid_q[idx_q] && (entry_rd_q.tag == tag_q);
    if (global_history_sel_q) begin
      look_hist = shared_history_q;
    end else if (look_hit || mode_q == btb_pkg::MODE_PREDICT) begin
      look_hist = entry_rd_q.hist;
    end else begin
      look_hist = '0;
    end
    look_hist = look_hist & hmask_q;
    if (global_table_sel_q) begin
      look_cidx = (look_hist ^ share_x_q) & hmask_q;
    end else begin
      look_cidx = look_hist;
    end
    look_new_hist = {look_hist[HW-2:0], taken_q} & hmask_q;
    look_flush = taken_q ? (pred_q != target_q) : (pred_q != seq_pc);
    look_clear = !look_hit && !global_table_sel_q;
  end

  // Counter value seen in the final stage.
  logic [btb_pkg::CtrW-1:0] cur_ctr;
  logic [btb_pkg::CtrW-1:0] new_ctr;
  always_comb begin
    if (use_init_q) begin
      cur_ctr = initial_counter_q;
    end else if (global_table_sel_q) begin
      cur_ctr = svalid_rd_q ? sctr_rd_q : initial_counter_q;
    end else begin
      cur_ctr = ectr_rd_q;
    end
    new_ctr = btb_pkg::ctr_train(cur_ctr, taken_q);
  end

  assign cfg_hit = cfg_we_i && (cfg_index_i <= btb_pkg::CFG_SHARE_MODE);

  // Entry memory.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      entry_rd_q <= entry_mem[in_idx];
    end
    if (state_q == S_LOOK && mode_q == btb_pkg::MODE_UPDATE) begin
      entry_mem[idx_q] <= '{
        tag:    tag_q,
        target: target_q,
        hist:   global_history_sel_q ? entry_rd_q.hist : look_new_hist
      };
    end
  end

  // Per-entry counter memory.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK && !look_clear) begin
      ectr_rd_q <= ectr_mem[{idx_q, look_cidx}];
    end
    if (state_q == S_CLR) begin
      ectr_mem[{idx_q, clr_cnt_q}] <= initial_counter_q;
    end else if (state_q == S_CRD && out_free && mode_q == btb_pkg::MODE_UPDATE &&
                 !global_table_sel_q) begin
      ectr_mem[{idx_q, cidx_q}] <= new_ctr;
    end
  end

  // Shared counter memory.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      sctr_rd_q <= sctr_mem[look_cidx];
    end
    if (state_q == S_CRD && out_free && mode_q == btb_pkg::MODE_UPDATE &&
        global_table_sel_q) begin
      sctr_mem[cidx_q] <= new_ctr;
    end
  end

  // Item and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q    <= mode_i;
      pc_q      <= pc_i;
      target_q  <= target_i;
      taken_q   <= taken_i;
      pred_q    <= predicted_target_i;
      idx_q     <= in_idx;
      tag_q     <= in_tag;
      hmask_q   <= in_hmask;
      share_x_q <= in_share_x;
    end
    if (state_q == S_LOOK) begin
      hit_q       <= look_hit;
      cidx_q      <= look_cidx;
      flush_q     <= look_flush;
      svalid_rd_q <= shared_valid_q[look_cidx];
    end
    if (state_q == S_CRD && out_free) begin
      branch_count_q <= branches_q;
      flush_count_q  <= flushes_q;
      if (mode_q == btb_pkg::MODE_PREDICT) begin
        predict_taken_q <= hit_q && (cur_ctr >= btb_pkg::CTR_WEAK_TAKEN);
        next_pc_q       <= (hit_q && (cur_ctr >= btb_pkg::CTR_WEAK_TAKEN)) ?
                           entry_rd_q.target : seq_pc;
        flush_out_q     <= 1'b0;
      end else begin
        predict_taken_q <= 1'b0;
        next_pc_q       <= '0;
        flush_out_q     <= flush_q;
      end
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btb_entries_q        <= 6'd1;
      history_bits_q       <= 4'd1;
      tag_bits_q           <= 5'd0;
      initial_counter_q    <= 2'd1;
      global_history_sel_q <= 1'b0;
      global_table_sel_q   <= 1'b0;
      share_mode_q         <= btb_pkg::SHARE_NONE;
      state_q              <= S_IDLE;
      entry_valid_q        <= '0;
      shared_valid_q       <= '0;
      shared_history_q     <= '0;
      branches_q           <= '0;
      flushes_q            <= '0;
      out_valid_q          <= 1'b0;
      clr_cnt_q            <= '0;
      use_init_q           <= 1'b0;
    end else begin
      if (state_q == S_CRD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_hit) begin
        case (cfg_index_i)
          btb_pkg::CFG_BTB_ENTRIES:     btb_entries_q        <= cfg_data_i;
          btb_pkg::CFG_HISTORY_BITS:    history_bits_q       <= cfg_data_i[3:0];
          btb_pkg::CFG_TAG_BITS:        tag_bits_q           <= cfg_data_i[4:0];
          btb_pkg::CFG_INITIAL_COUNTER: initial_counter_q    <= cfg_data_i[1:0];
          btb_pkg::CFG_GLOBAL_HISTORY:  global_history_sel_q <= cfg_data_i[0];
          btb_pkg::CFG_GLOBAL_TABLE:    global_table_sel_q   <= cfg_data_i[0];
          btb_pkg::CFG_SHARE_MODE:      share_mode_q         <= cfg_data_i[1:0];
          default: ;
        endcase
        entry_valid_q    <= '0;
        shared_valid_q   <= '0;
        shared_history_q <= '0;
        branches_q       <= '0;
        flushes_q        <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) state_q <= S_LOOK;
        end
        S_LOOK: begin
          use_init_q <= (mode_q == btb_pkg::MODE_UPDATE) && look_clear;
          clr_cnt_q  <= '0;
          if (mode_q == btb_pkg::MODE_UPDATE) begin
            branches_q <= branches_q + 32'd1;
            if (look_flush) flushes_q <= flushes_q + 32'd1;
            entry_valid_q[idx_q] <= 1'b1;
            if (global_history_sel_q) shared_history_q <= look_new_hist;
            if (look_clear) begin
              state_q <= S_CLR;
            end else begin
              state_q <= S_CRD;
            end
          end else begin
            state_q <= S_CRD;
          end
        end
        S_CLR: begin
          // Return the newly allocated row to the initial counter.
          clr_cnt_q <= clr_cnt_q + HW'(1);
          if (clr_cnt_q == hmask_q) state_q <= S_CRD;
        end
        S_CRD: begin
          if (out_free) begin
            if (mode_q == btb_pkg::MODE_UPDATE && global_table_sel_q) begin
              shared_valid_q[cidx_q] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign predict_taken_o = predict_taken_q;
  assign next_pc_o       = next_pc_q;
  assign flush_o         = flush_out_q;
  assign branch_count_o  = branch_count_q;
  assign flush_count_o   = flush_count_q;

  a_clear_only_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (mode_q == btb_pkg::MODE_UPDATE && !global_table_sel_q))
    else $error("row clear outside a per-entry table update");

  a_xfer_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_LOOK))
    else $error("input transfer did not start a lookup");

  a_result_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not registered after counter stage");

  a_update_allocates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && mode_q == btb_pkg::MODE_UPDATE && !cfg_hit) |=>
      entry_valid_q[idx_q])
    else $error("update left its entry invalid");

endmodule
